/* hw/rtl/epsm_pkg.sv */
// Package for the encoder period speed meter: codes, types and constants.
package epsm_pkg;

  // Input command codes
  localparam logic [1:0] CMD_CAPTURE  = 2'd0;
  localparam logic [1:0] CMD_OVERFLOW = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_SPAN    = 2'd0;
  localparam logic [1:0] REG_MAX_OVF = 2'd1;
  localparam logic [1:0] REG_SPEED_K = 2'd2;
  localparam logic [1:0] REG_DPP     = 2'd3;

  // Register reset values
  localparam logic [15:0] SPAN_RST    = 16'd65535;
  localparam logic [3:0]  MAX_OVF_RST = 4'd6;
  localparam logic [31:0] SPEED_K_RST = 32'd7915878;
  localparam logic [31:0] DPP_RST     = 32'd16085;

  // Saturation limits and special values
  localparam logic [3:0]  CNT_MAX   = 4'd15;
  localparam logic [23:0] SPEED_MAX = 24'hFF_FFFF;
  localparam logic [47:0] DIST_MAX  = 48'hFFFF_FFFF_FFFF;
  localparam logic [21:0] PER_STOP  = 22'h3F_FFFF;  // -1 in 22 bits
  localparam int          DIV_STEPS = 32;

  // Decoded operation carried from front to back
  typedef enum logic [1:0] {
    OP_CAPTURE,
    OP_OVERFLOW,
    OP_CLEAR,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        side;
    logic [15:0] cap;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [15:0] span;
    logic [3:0]  max_ovf;
    logic [31:0] speed_k;
    logic [31:0] dpp;
  } cfg_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_OUT
  } back_state_t;

endpackage

/* hw/rtl/epsm_in_if.sv */
// Input item channel of the encoder period speed meter.
interface epsm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic        side;
  logic [15:0] capture_value;

  modport source (output valid, command, side, capture_value, input ready);
  modport sink   (input valid, command, side, capture_value, output ready);
endinterface

/* hw/rtl/epsm_out_if.sv */
// Result item channel of the encoder period speed meter.
interface epsm_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] vel_left;
  logic [23:0] vel_right;
  logic [47:0] distance_left;
  logic [47:0] distance_right;
  logic        stopped_left;
  logic        stopped_right;

  modport source (output valid, vel_left, vel_right, distance_left, distance_right,
                  stopped_left, stopped_right, input ready);
  modport sink   (input valid, vel_left, vel_right, distance_left, distance_right,
                  stopped_left, stopped_right, output ready);
endinterface

/* hw/rtl/epsm_queue.sv */
// Two-entry queue between the front end and the back end.
module epsm_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  epsm_pkg::q_entry_t  push_data,
  input  logic                pop,
  output epsm_pkg::q_entry_t  pop_data,
  output epsm_pkg::q_stat_t   stat
);
  import epsm_pkg::*;

  q_entry_t    mem_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  count_r;
  logic        do_push, do_pop;

  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* hw/rtl/epsm_front.sv */
// Front end: accepts input items, decodes the command and feeds the queue.
module epsm_front (
  input  logic                clk,
  input  logic                rst_n,
  epsm_in_if.sink             in_ch,
  output logic                push,
  output epsm_pkg::q_entry_t  push_data,
  input  epsm_pkg::q_stat_t   q_stat
);
  import epsm_pkg::*;

  logic     hold_valid_r, hold_valid_nxt;
  q_entry_t hold_r;
  q_entry_t dec;
  logic     accept;

  assign push         = hold_valid_r && !q_stat.full;
  assign push_data    = hold_r;
  assign in_ch.ready  = !hold_valid_r || !q_stat.full;
  assign accept       = in_ch.valid && in_ch.ready;

  // Command decode
  always_comb begin
    dec.side = in_ch.side;
    dec.cap  = in_ch.capture_value;
    unique case (in_ch.command)
      CMD_CAPTURE:  dec.op = OP_CAPTURE;
      CMD_OVERFLOW: dec.op = OP_OVERFLOW;
      CMD_CLEAR:    dec.op = OP_CLEAR;
      default:      dec.op = OP_NONE;
    endcase
  end

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  // Holding stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= dec;
    end
  end

endmodule

/* hw/rtl/epsm_back.sv */
// Back end: wheel state update, serial speed divide and result register.
module epsm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  epsm_pkg::cfg_t      cfg,
  input  logic                speed_k_wr,
  input  epsm_pkg::q_entry_t  ent,
  input  epsm_pkg::q_stat_t   q_stat,
  output logic                pop,
  epsm_out_if.source          out_ch
);
  import epsm_pkg::*;

  back_state_t state_r, state_nxt;

  // Per-wheel state
  logic [15:0] last_r [2], last_nxt [2];
  logic [3:0]  ovf_r  [2], ovf_nxt  [2];
  logic [21:0] per_r  [2], per_nxt  [2];
  logic [47:0] dist_r [2], dist_nxt [2];
  logic [23:0] spd_r  [2], spd_nxt  [2];
  logic [1:0]  dirty_r, dirty_nxt;

  // Divider
  logic        wheel_r, wheel_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [20:0] rem_r, rem_nxt;
  logic [20:0] div_r, div_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [21:0] shifted;
  logic [22:0] diff;
  logic [31:0] q_step;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] o_spd_r [2];
  logic [47:0] o_dist_r [2];
  logic [1:0]  o_stop_r;
  logic        load_out;

  // Event arithmetic
  logic        w;
  logic [19:0] prod;
  logic [21:0] per_cap;
  logic [48:0] dist_sum;
  logic [3:0]  ovf_inc;
  logic        sel;

  assign w        = ent.side;
  assign prod     = 20'(ovf_r[w]) * 20'(cfg.span);
  assign per_cap  = 22'({6'd0, ent.cap}) - 22'({6'd0, last_r[w]}) + {2'd0, prod};
  assign dist_sum = {1'b0, dist_r[w]} + {17'd0, cfg.dpp};
  assign ovf_inc  = (ovf_r[w] == CNT_MAX) ? CNT_MAX : ovf_r[w] + 4'd1;
  assign sel      = !dirty_r[0];

  // One restoring divide step
  assign shifted = {rem_r, quo_r[31]};
  assign diff    = {1'b0, shifted} - {2'd0, div_r};
  assign q_step  = {quo_r[30:0], ~diff[22]};

  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    ovf_nxt   = ovf_r;
    per_nxt   = per_r;
    dist_nxt  = dist_r;
    spd_nxt   = spd_r;
    dirty_nxt = dirty_r;
    wheel_nxt = wheel_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    quo_nxt   = quo_r;
    pop       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          state_nxt = S_CHECK;
          case (ent.op)
            OP_CAPTURE: begin
              dist_nxt[w]  = dist_sum[48] ? DIST_MAX : dist_sum[47:0];
              per_nxt[w]   = per_cap;
              last_nxt[w]  = ent.cap;
              ovf_nxt[w]   = 4'd0;
              dirty_nxt[w] = 1'b1;
            end
            OP_OVERFLOW: begin
              ovf_nxt[w] = ovf_inc;
              if (ovf_inc > cfg.max_ovf) begin
                per_nxt[w]   = PER_STOP;
                dirty_nxt[w] = 1'b1;
              end
            end
            OP_CLEAR: begin
              dist_nxt[0] = 48'd0;
              dist_nxt[1] = 48'd0;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (dirty_r == 2'b00) begin
          state_nxt = S_OUT;
        end else if (per_r[sel][21] || per_r[sel] == 22'd0) begin
          // period not positive: speed is zero, no divide
          spd_nxt[sel]   = 24'd0;
          dirty_nxt[sel] = 1'b0;
        end else begin
          wheel_nxt = sel;
          div_nxt   = per_r[sel][20:0];
          rem_nxt   = 21'd0;
          quo_nxt   = cfg.speed_k;
          cnt_nxt   = 5'd0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = diff[22] ? shifted[20:0] : diff[20:0];
        quo_nxt = q_step;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(DIV_STEPS - 1)) begin
          spd_nxt[wheel_r]   = (|q_step[31:24]) ? SPEED_MAX : q_step[23:0];
          dirty_nxt[wheel_r] = 1'b0;
          state_nxt          = S_CHECK;
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // a new speed constant invalidates both cached speeds
    if (speed_k_wr) begin
      dirty_nxt = 2'b11;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and wheel state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dirty_r     <= 2'b00;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        last_r[i] <= 16'd0;
        ovf_r[i]  <= 4'd0;
        per_r[i]  <= 22'd0;
        dist_r[i] <= 48'd0;
        spd_r[i]  <= 24'd0;
      end
    end else begin
      state_r     <= state_nxt;
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
      last_r      <= last_nxt;
      ovf_r       <= ovf_nxt;
      per_r       <= per_nxt;
      dist_r      <= dist_nxt;
      spd_r       <= spd_nxt;
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    wheel_r <= wheel_nxt;
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    quo_r   <= quo_nxt;
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (load_out) begin
      for (int i = 0; i < 2; i++) begin
        o_spd_r[i]  <= spd_r[i];
        o_dist_r[i] <= dist_r[i];
        o_stop_r[i] <= per_r[i][21] || (per_r[i] == 22'd0);
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.vel_left       = o_spd_r[0];
  assign out_ch.vel_right      = o_spd_r[1];
  assign out_ch.distance_left  = o_dist_r[0];
  assign out_ch.distance_right = o_dist_r[1];
  assign out_ch.stopped_left   = o_stop_r[0];
  assign out_ch.stopped_right  = o_stop_r[1];

endmodule

/* hw/rtl/encoder_period_speed_meter_core.sv */
// Encoder period speed meter: top level with configuration registers.
//
// Input channel in_ch takes one event per item: a capture or a timer
// overflow for one wheel, or a clear of both distances. Every item gives
// exactly one result item on out_ch with speed, distance and stopped flag
// of both wheels.
// The front end registers and decodes each item into a two-entry queue; the
// back end applies it to the wheel state and recomputes the speed of any
// wheel whose period changed with a 32-step restoring divider, one quotient
// bit per cycle. An overflow or clear item needs no divide; a capture with
// a positive period passes through the divider before its result.
// A write of the speed_k register marks both speeds for recomputation, so
// the next item after it may need two divides.
// The back end handles one item at a time, with up to two divides each.
// A finished result waits in the output register while the back end takes
// the next queued item; if out_ch stalls, the queue fills and in_ch drops
// ready. Synchronous reset clears all wheel state: both wheels report
// stopped with zero speed and zero distance. Registers reset to their
// defaults and are written through the APB port; the user must write them
// only while the block is idle; the block does not enforce this.
module encoder_period_speed_meter_core (
  input  logic        clk,
  input  logic        rst_n,
  epsm_in_if.sink     in_ch,
  epsm_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import epsm_pkg::*;

  cfg_t       cfg_r;
  logic       cfg_wr;
  logic       speed_k_wr;
  logic [1:0] reg_idx;
  logic       push, pop;
  q_entry_t   push_data, pop_data;
  q_stat_t    q_stat;

  assign pready     = 1'b1;
  assign reg_idx    = paddr[3:2];
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign speed_k_wr = cfg_wr && (reg_idx == REG_SPEED_K);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.span    <= SPAN_RST;
      cfg_r.max_ovf <= MAX_OVF_RST;
      cfg_r.speed_k <= SPEED_K_RST;
      cfg_r.dpp     <= DPP_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_SPAN:    cfg_r.span    <= pwdata[15:0];
        REG_MAX_OVF: cfg_r.max_ovf <= pwdata[3:0];
        REG_SPEED_K: cfg_r.speed_k <= pwdata;
        REG_DPP:     cfg_r.dpp     <= pwdata;
        default:     ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (reg_idx)
      REG_SPAN:    prdata = {16'd0, cfg_r.span};
      REG_MAX_OVF: prdata = {28'd0, cfg_r.max_ovf};
      REG_SPEED_K: prdata = cfg_r.speed_k;
      REG_DPP:     prdata = cfg_r.dpp;
      default:     prdata = 32'd0;
    endcase
  end

  epsm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push      (push),
    .push_data (push_data),
    .q_stat    (q_stat)
  );

  epsm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  epsm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .speed_k_wr (speed_k_wr),
    .ent        (pop_data),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

/* hw/rtl/epsm_checker.sv */
// Port-level checker for the encoder period speed meter, bound to the top.
module epsm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] vel_left,
  input logic [23:0] vel_right,
  input logic        stopped_left,
  input logic        stopped_right
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stopped wheel reports zero speed
  a_stop_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && stopped_left |-> vel_left == 24'd0)
    else $error("left wheel stopped with nonzero speed");

  a_stop_right: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && stopped_right |-> vel_right == 24'd0)
    else $error("right wheel stopped with nonzero speed");

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

endmodule

bind encoder_period_speed_meter_core epsm_checker u_epsm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .vel_left      (out_ch.vel_left),
  .vel_right     (out_ch.vel_right),
  .stopped_left  (out_ch.stopped_left),
  .stopped_right (out_ch.stopped_right)
);

/* verif/encoder_period_speed_meter_core_tb.sv */
// Testbench for encoder_period_speed_meter_core: self-checking event stream vs. wheel model.
`timescale 1ns / 100ps

module encoder_period_speed_meter_core_tb;
  import epsm_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 100;
  localparam int FREE_PULSES = 40;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // One reading of both wheels
  typedef struct packed {
    logic [23:0] speed_l;
    logic [23:0] speed_r;
    logic [47:0] dist_l;
    logic [47:0] dist_r;
    logic        stop_l;
    logic        stop_r;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  epsm_in_if  in_ch ();
  epsm_out_if out_ch ();

  encoder_period_speed_meter_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Wheel model: registers and per-wheel state
  cfg_t        m_cfg;
  logic [15:0] m_last[2];
  logic [3:0]  m_ovf[2];
  int          m_period[2];
  logic [47:0] m_dist[2];

  reading_t    readings_due[$];
  int          errors = 0;
  bit          rx_free = 1'b0;
  bit          tx_free = 1'b0;
  int          burst_left = 0;
  int          rx_mode = 0;
  int          rx_left = 0;
  int          quiet_cycles = 0;
  logic [15:0] sent_cap[2];

  task automatic model_reset();
    m_cfg.span    = SPAN_RST;
    m_cfg.max_ovf = MAX_OVF_RST;
    m_cfg.speed_k = SPEED_K_RST;
    m_cfg.dpp     = DPP_RST;
    for (int w = 0; w < 2; w++) begin
      m_last[w]   = '0;
      m_ovf[w]    = '0;
      m_period[w] = 0;
      m_dist[w]   = '0;
      sent_cap[w] = '0;
    end
  endtask

  // Speed from period: zero when not positive, saturated to 24 bits
  function automatic logic [23:0] wheel_speed(input int per);
    logic [31:0] q;
    if (per <= 0) return '0;
    q = m_cfg.speed_k / unsigned'(per);
    return (q > 32'(SPEED_MAX)) ? SPEED_MAX : q[23:0];
  endfunction

  // Apply one event to the model and return the reading it produces
  function automatic reading_t meter_apply(input logic [1:0] cmd, input logic side,
                                           input logic [15:0] cap);
    logic [48:0] sum;
    longint      span_counts;
    reading_t    r;
    case (cmd)
      CMD_CAPTURE: begin
        sum = m_dist[side] + m_cfg.dpp;
        m_dist[side] = sum[48] ? DIST_MAX : sum[47:0];
        span_counts = longint'(m_ovf[side]) * longint'(m_cfg.span);
        m_period[side] = int'(longint'(cap) - longint'(m_last[side]) + span_counts);
        m_last[side] = cap;
        m_ovf[side] = '0;
      end
      CMD_OVERFLOW: begin
        if (m_ovf[side] < CNT_MAX) m_ovf[side] = m_ovf[side] + 4'd1;
        if (m_ovf[side] > m_cfg.max_ovf) m_period[side] = -1;
      end
      CMD_CLEAR: begin
        m_dist[0] = '0;
        m_dist[1] = '0;
      end
      default: ;
    endcase
    r.speed_l = wheel_speed(m_period[0]);
    r.speed_r = wheel_speed(m_period[1]);
    r.dist_l  = m_dist[0];
    r.dist_r  = m_dist[1];
    r.stop_l  = (m_period[0] <= 0);
    r.stop_r  = (m_period[1] <= 0);
    return r;
  endfunction

  // Send one event item; bursts with random gaps unless tx_free
  task automatic send_event(input logic [1:0] cmd, input logic side, input logic [15:0] cap);
    int gap;
    in_ch.valid         <= 1'b1;
    in_ch.command       <= cmd;
    in_ch.side          <= side;
    in_ch.capture_value <= cap;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    readings_due.push_back(meter_apply(cmd, side, cap));
    if (cmd == CMD_CAPTURE) sent_cap[side] = cap;
    if (!tx_free) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        burst_left = $urandom_range(0, 24);
        if (gap > 0) begin
          in_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  // Hold the input and wait until every expected reading has come back
  task automatic wait_readings_done();
    in_ch.valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SPAN:    m_cfg.span    = val[15:0];
      REG_MAX_OVF: m_cfg.max_ovf = val[3:0];
      REG_SPEED_K: m_cfg.speed_k = val;
      REG_DPP:     m_cfg.dpp     = val;
      default: ;
    endcase
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [31:0] want);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got !== want) begin
      errors++;
      $display("%0t: register %0d expected %h actual %h", $time, idx, want, got);
    end
  endtask

  task automatic set_meter_config(input logic [15:0] span, input logic [3:0] max_ovf,
                                  input logic [31:0] speed_k, input logic [31:0] dpp);
    wait_readings_done();
    write_reg(REG_SPAN, {16'd0, span});
    write_reg(REG_MAX_OVF, {28'd0, max_ovf});
    write_reg(REG_SPEED_K, speed_k);
    write_reg(REG_DPP, dpp);
  endtask

  // Reset values, readback of extremes, and the reading right after reset
  task automatic test_register_access();
    check_reg(REG_SPAN, {16'd0, SPAN_RST});
    check_reg(REG_MAX_OVF, {28'd0, MAX_OVF_RST});
    check_reg(REG_SPEED_K, SPEED_K_RST);
    check_reg(REG_DPP, DPP_RST);
    send_event(CMD_UNUSED, 1'b1, 16'hFFFF);
    set_meter_config(16'd1, 4'd0, 32'd0, 32'd0);
    check_reg(REG_SPAN, 32'd1);
    check_reg(REG_MAX_OVF, 32'd0);
    check_reg(REG_SPEED_K, 32'd0);
    check_reg(REG_DPP, 32'd0);
    set_meter_config(16'hFFFF, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    check_reg(REG_SPAN, 32'h0000_FFFF);
    check_reg(REG_MAX_OVF, 32'd15);
    check_reg(REG_SPEED_K, 32'hFFFF_FFFF);
    check_reg(REG_DPP, 32'hFFFF_FFFF);
    set_meter_config(SPAN_RST, MAX_OVF_RST, SPEED_K_RST, DPP_RST);
  endtask

  // Capture extremes, backward capture, clear and the unused command
  task automatic test_capture_cases();
    send_event(CMD_CAPTURE, 1'b0, 16'd0);
    send_event(CMD_CAPTURE, 1'b0, 16'hFFFF);
    send_event(CMD_CAPTURE, 1'b0, 16'hFFFF);
    send_event(CMD_CAPTURE, 1'b1, 16'd1000);
    send_event(CMD_CAPTURE, 1'b1, 16'd3000);
    // backward capture with no overflow: stopped
    send_event(CMD_CAPTURE, 1'b1, 16'd2500);
    send_event(CMD_OVERFLOW, 1'b1, 16'hFFFF);
    send_event(CMD_CAPTURE, 1'b1, 16'd100);
    // clear ignores side; unused command only reports
    send_event(CMD_CLEAR, 1'b1, 16'h5555);
    send_event(CMD_UNUSED, 1'b0, 16'hAAAA);
    send_event(CMD_CAPTURE, 1'b0, 16'd1);
    send_event(CMD_CAPTURE, 1'b0, 16'h5555);
    send_event(CMD_CAPTURE, 1'b1, 16'hAAAA);
    // period of one with the largest constant: speed saturates
    set_meter_config(SPAN_RST, MAX_OVF_RST, 32'hFFFF_FFFF, DPP_RST);
    send_event(CMD_CAPTURE, 1'b0, 16'h5556);
    send_event(CMD_CAPTURE, 1'b1, 16'hAAAB);
    send_event(CMD_CLEAR, 1'b0, 16'd0);
  endtask

  // Count saturation, limit of fifteen, limits of zero and fourteen
  task automatic test_overflow_limits();
    set_meter_config(16'hFFFF, 4'd15, SPEED_K_RST, DPP_RST);
    send_event(CMD_CAPTURE, 1'b0, 16'd100);
    send_event(CMD_CAPTURE, 1'b0, 16'd200);
    repeat (17) send_event(CMD_OVERFLOW, 1'b0, 16'd0);
    send_event(CMD_CAPTURE, 1'b0, 16'hFFFF);
    set_meter_config(16'd1, 4'd0, SPEED_K_RST, DPP_RST);
    send_event(CMD_OVERFLOW, 1'b1, 16'd0);
    send_event(CMD_CAPTURE, 1'b1, 16'd7);
    set_meter_config(16'd1000, 4'd14, SPEED_K_RST, DPP_RST);
    send_event(CMD_CAPTURE, 1'b1, 16'd9);
    repeat (16) send_event(CMD_OVERFLOW, 1'b1, 16'd0);
    send_event(CMD_CAPTURE, 1'b1, 16'd0);
  endtask

  // Zero and full speed constant, zero distance step
  task automatic test_speed_extremes();
    set_meter_config(16'd1, 4'd6, 32'd0, 32'hFFFF_FFFF);
    send_event(CMD_CAPTURE, 1'b0, 16'd10);
    send_event(CMD_CAPTURE, 1'b0, 16'd11);
    send_event(CMD_CAPTURE, 1'b1, 16'd40000);
    set_meter_config(16'd1, 4'd6, 32'hFFFF_FFFF, 32'd0);
    send_event(CMD_CAPTURE, 1'b0, 16'd12);
    send_event(CMD_CAPTURE, 1'b1, 16'd65000);
    send_event(CMD_OVERFLOW, 1'b1, 16'd0);
    send_event(CMD_CAPTURE, 1'b1, 16'd0);
  endtask

  // Random stream: mostly well-formed encoder timing with noise mixed in
  task automatic random_events(input int count);
    int          sent;
    int          kind;
    int          run;
    logic        side;
    logic [15:0] cap;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 99);
      side = 1'($urandom_range(0, 1));
      if (kind < 55) begin
        if ($urandom_range(0, 4) == 0) begin
          cap = 16'($urandom_range(0, 65535));
        end else begin
          cap = sent_cap[side] + 16'($urandom_range(1, 4000));
          // timer wrapped: the overflow comes before the capture
          if (cap < sent_cap[side]) begin
            send_event(CMD_OVERFLOW, side, 16'($urandom_range(0, 65535)));
          end
        end
        send_event(CMD_CAPTURE, side, cap);
        sent++;
      end else if (kind < 80) begin
        send_event(CMD_OVERFLOW, side, 16'($urandom_range(0, 65535)));
        sent++;
      end else if (kind < 86) begin
        // stalled wheel: a run of overflows
        run = $urandom_range(2, 17);
        repeat (run) send_event(CMD_OVERFLOW, side, 16'($urandom_range(0, 65535)));
        sent += run;
      end else if (kind < 90) begin
        send_event(CMD_CLEAR, side, 16'($urandom_range(0, 65535)));
        sent++;
      end else if (kind < 94) begin
        send_event(CMD_UNUSED, side, 16'($urandom_range(0, 65535)));
        sent++;
      end else begin
        send_event(2'($urandom_range(0, 3)), side, 16'($urandom_range(0, 65535)));
        sent++;
      end
    end
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_meter_config(16'd1, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        1: set_meter_config(16'hFFFF, 4'd14, 32'd0, 32'd0);
        2: set_meter_config(16'($urandom_range(1, 65535)), 4'd15, $urandom(), $urandom());
        default: set_meter_config(16'($urandom_range(1, 65535)),
                                  4'($urandom_range(0, 14)),
                                  ($urandom_range(0, 2) == 0) ? SPEED_K_RST : $urandom(),
                                  $urandom_range(0, 1 << 20));
      endcase
      random_events(65);
      // hold off until the block has drained, then carry on
      if (phase == 3) wait_readings_done();
      random_events(65);
    end
  endtask

  // Full-rate run: free sender and receiver; repeated captures give a zero
  // period, so no divide holds items up
  task automatic test_free_flow();
    set_meter_config(SPAN_RST, MAX_OVF_RST, SPEED_K_RST, 32'hFFFF_FFFF);
    rx_free = 1'b1;
    tx_free = 1'b1;
    send_event(CMD_CLEAR, 1'b0, 16'd0);
    repeat (FREE_PULSES) send_event(CMD_CAPTURE, 1'b0, 16'h1234);
    wait_readings_done();
    rx_free = 1'b0;
    tx_free = 1'b0;
    send_event(CMD_CAPTURE, 1'b0, 16'h2000);
    send_event(CMD_CAPTURE, 1'b1, 16'h0010);
  endtask

  // Main sequence
  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.command       <= CMD_CAPTURE;
    in_ch.side          <= 1'b0;
    in_ch.capture_value <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    model_reset();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_capture_cases();
    test_overflow_limits();
    test_speed_extremes();
    test_random();
    test_free_flow();

    wait_readings_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && readings_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Receiver: ready pattern switches between free, light, heavy and random stalls
  always @(posedge clk) begin : rx_pattern
    logic take;
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 160);
    end
    rx_left--;
    case (rx_mode)
      0:       take = 1'b1;
      1:       take = 1'($urandom_range(0, 1));
      2:       take = ($urandom_range(0, 7) != 0);
      default: take = ($urandom_range(0, 11) == 0);
    endcase
    out_ch.ready <= rx_free | take;
  end

  task automatic cmp_field(input string name, input logic [47:0] want, input logic [47:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Compare each accepted reading with the oldest one due
  always @(posedge clk) begin : reading_check
    reading_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (readings_due.size() == 0) begin
        errors++;
        $display("%0t: reading arrived with none expected", $time);
      end else begin
        want = readings_due.pop_front();
        cmp_field("vel_left", want.speed_l, out_ch.vel_left);
        cmp_field("vel_right", want.speed_r, out_ch.vel_right);
        cmp_field("distance_left", want.dist_l, out_ch.distance_left);
        cmp_field("distance_right", want.dist_r, out_ch.distance_right);
        cmp_field("stopped_left", want.stop_l, out_ch.stopped_left);
        cmp_field("stopped_right", want.stop_r, out_ch.stopped_right);
      end
    end
  end

  // Watchdog: too long without any item moving on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

/* sim.f */
hw/rtl/epsm_pkg.sv
hw/rtl/epsm_in_if.sv
hw/rtl/epsm_out_if.sv
hw/rtl/epsm_queue.sv
hw/rtl/epsm_front.sv
hw/rtl/epsm_back.sv
hw/rtl/encoder_period_speed_meter_core.sv
hw/rtl/epsm_checker.sv
verif/encoder_period_speed_meter_core_tb.sv
